// File: rtl/core/bsa_pkg.sv
// Shared types and constants for the bitmap slab allocator.
// No dependencies.
`timescale 1ns / 1ps
package bsa_pkg;
  localparam int PAGE_SHIFT = 12;
  localparam int WORDS_PER_SLAB = 8;
  localparam int SLOTS_PER_SLAB = 512;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOSLAB = 2'd1;
  localparam logic [1:0] ST_DOUBLE = 2'd2;
  localparam logic [1:0] ST_BADADDR = 2'd3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE = 1'b1;

  localparam logic [0:0] REG_OBJECT_SIZE = 1'b0;
  localparam logic [0:0] REG_BASE_PAGE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_DERIVE, S_PICK, S_RDWORD, S_SCAN, S_OPEN, S_CLEAR,
    S_FCHK, S_FDIV, S_FRD, S_FTEST, S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic derive_start;
    logic derive_step;
    logic latch_in;
    logic pick;
    logic rd_word;
    logic scan_word;
    logic set_full;
    logic open_page;
    logic clear_word;
    logic div_start;
    logic div_step;
    logic rd_free;
    logic free_commit;
    logic [1:0] res_status;
    logic emit;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic derive_done;
    logic word_has_free;
    logic word_last;
    logic slabs_all_open;
    logic clear_done;
    logic free_bad;
    logic div_done;
    logic div_bad;
    logic slot_set;
  } sts_t;
endpackage

// File: rtl/core/bsa_ctrl.sv
// Controller state machine of the bitmap slab allocator.
// Depends on bsa_pkg.
`timescale 1ns / 1ps
module bsa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            cmd,
  input  logic            cfg_size_we,
  input  bsa_pkg::sts_t   sts,
  output logic            busy,
  output bsa_pkg::ctl_t   ctl
);
  bsa_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= bsa_pkg::S_DERIVE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    ctl = '0;
    busy = (state != bsa_pkg::S_IDLE);
    case (state)
      bsa_pkg::S_IDLE: begin
        if (cfg_size_we) begin
          ctl.derive_start = 1'b1;
          state_next = bsa_pkg::S_DERIVE;
        end else if (start) begin
          ctl.latch_in = 1'b1;
          state_next = (cmd == bsa_pkg::CMD_FREE) ? bsa_pkg::S_FCHK : bsa_pkg::S_PICK;
        end
      end
      bsa_pkg::S_DERIVE: begin
        ctl.derive_step = 1'b1;
        if (sts.derive_done) state_next = bsa_pkg::S_IDLE;
      end
      bsa_pkg::S_PICK: begin
        ctl.pick = 1'b1;
        state_next = bsa_pkg::S_RDWORD;
      end
      bsa_pkg::S_RDWORD: begin
        ctl.rd_word = 1'b1;
        state_next = bsa_pkg::S_SCAN;
      end
      bsa_pkg::S_SCAN: begin
        if (sts.word_has_free) begin
          ctl.scan_word = 1'b1;
          ctl.res_status = bsa_pkg::ST_OK;
          ctl.emit = 1'b1;
          state_next = bsa_pkg::S_DONE;
        end else if (!sts.word_last) begin
          ctl.scan_word = 1'b1;
          state_next = bsa_pkg::S_RDWORD;
        end else begin
          ctl.set_full = 1'b1;
          if (sts.slabs_all_open) begin
            ctl.res_status = bsa_pkg::ST_NOSLAB;
            ctl.emit = 1'b1;
            state_next = bsa_pkg::S_DONE;
          end else state_next = bsa_pkg::S_OPEN;
        end
      end
      bsa_pkg::S_OPEN: begin
        ctl.open_page = 1'b1;
        state_next = bsa_pkg::S_CLEAR;
      end
      bsa_pkg::S_CLEAR: begin
        ctl.clear_word = 1'b1;
        if (sts.clear_done) state_next = bsa_pkg::S_PICK;
      end
      bsa_pkg::S_FCHK: begin
        if (sts.free_bad) begin
          ctl.res_status = bsa_pkg::ST_BADADDR;
          ctl.emit = 1'b1;
          state_next = bsa_pkg::S_DONE;
        end else begin
          ctl.div_start = 1'b1;
          state_next = bsa_pkg::S_FDIV;
        end
      end
      bsa_pkg::S_FDIV: begin
        ctl.div_step = 1'b1;
        if (sts.div_done) state_next = bsa_pkg::S_FRD;
      end
      bsa_pkg::S_FRD: begin
        if (sts.div_bad) begin
          ctl.res_status = bsa_pkg::ST_BADADDR;
          ctl.emit = 1'b1;
          state_next = bsa_pkg::S_DONE;
        end else begin
          ctl.rd_free = 1'b1;
          state_next = bsa_pkg::S_FTEST;
        end
      end
      bsa_pkg::S_FTEST: begin
        ctl.emit = 1'b1;
        if (sts.slot_set) begin
          ctl.free_commit = 1'b1;
          ctl.res_status = bsa_pkg::ST_OK;
        end else ctl.res_status = bsa_pkg::ST_DOUBLE;
        state_next = bsa_pkg::S_DONE;
      end
      bsa_pkg::S_DONE: state_next = bsa_pkg::S_IDLE;
      default: state_next = bsa_pkg::S_IDLE;
    endcase
  end
endmodule

// File: rtl/core/bsa_datapath.sv
// Datapath of the bitmap slab allocator: configuration, bitmap memory,
// derivation and division units. Depends on bsa_pkg.
`timescale 1ns / 1ps
module bsa_datapath #(
  parameter int MAX_SLABS = 8,
  parameter int HEADER_BYTES = 64,
  parameter int MAX_BITMAP_BYTES = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [0:0]    cfg_idx,
  input  logic [35:0]   cfg_data,
  input  logic          cmd,
  input  logic [47:0]   free_address,
  input  bsa_pkg::ctl_t ctl,
  output bsa_pkg::sts_t sts,
  output logic          result_valid,
  output logic [47:0]   object_address,
  output logic [1:0]    status
);
  localparam int SW = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;
  localparam int OW = $clog2(MAX_SLABS + 1);
  localparam int DEPTH = MAX_SLABS * bsa_pkg::WORDS_PER_SLAB;
  localparam int AW = SW + 3;
  localparam int AVAIL = 4096 - HEADER_BYTES;

  logic [11:0] object_size;
  logic [35:0] base_page;
  logic [63:0] mem [DEPTH];
  logic [MAX_SLABS-1:0] full;
  logic [OW-1:0] open_cnt;
  logic [6:0] bm_bytes;
  logic [9:0] per_slab;

  logic [12:0] size_r;
  always_comb begin
    size_r = ({1'b0, object_size} + 13'd7) & 13'h1FF8;
    if (size_r == 13'd0) size_r = 13'd8;
  end

  // derivation: try one bitmap size per cycle, then divide for object count
  logic [6:0] db;
  logic       dphase;
  logic [11:0] drem;
  logic [11:0] dnum;
  logic [11:0] dq;
  logic [3:0]  dcnt;
  logic [21:0] dprod;
  logic [12:0] dtrial;
  always_comb begin
    dprod = 22'(size_r) * 22'(db);
  end
  assign dtrial = {drem, dnum[11]};
  // (avail-b)/(8b) <= size  <=>  (avail-b) < 8b(size+1)
  logic dpass;
  assign dpass = (25'(AVAIL) - 25'(db)) < ((25'(dprod) + 25'(db)) << 3);

  // free division
  logic [11:0] frem, fnum;
  logic [11:0] fq;
  logic [3:0]  fcnt;
  logic [SW-1:0] fslab;
  logic [12:0] ftrial;
  assign ftrial = {frem, fnum[11]};

  // alloc scan
  logic [SW-1:0] aslab;
  logic [2:0]   aword;
  logic [63:0]  rdw;
  logic [AW-1:0] clr_addr;
  logic [2:0]   clr_cnt;
  logic         init_clr;

  logic [AW-1:0] addr;
  always_comb begin
    addr = {aslab, aword};
    if (ctl.rd_free || ctl.free_commit) addr = {fslab, fq[8:6]};
  end

  // find free slot in the word under the object count
  logic [9:0] base_idx;
  logic [63:0] avail_mask, freem;
  logic [5:0]  fbit;
  logic        has_free;
  assign base_idx = {1'b0, aword, 6'd0};
  always_comb begin
    for (int i = 0; i < 64; i++)
      avail_mask[i] = (10'(base_idx + 10'(i)) < per_slab);
    freem = ~rdw & avail_mask;
    fbit = '0;
    for (int i = 63; i >= 0; i--) if (freem[i]) fbit = 6'(i);
  end
  assign has_free = |freem;

  logic [47:0] latched_addr;
  logic        cmd_l;
  logic [35:0] rel;
  logic [11:0] off, first;
  assign rel = latched_addr[47:12] - base_page;
  assign off = latched_addr[11:0];
  assign first = 12'(HEADER_BYTES) + 12'(bm_bytes);

  logic [21:0] mulp;
  logic [9:0]  slot_idx;
  assign slot_idx = {1'b0, aword, fbit};
  assign mulp = 22'(size_r) * 22'(slot_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      object_size <= 12'd64;
      base_page <= '0;
    end else if (cfg_we) begin
      if (cfg_idx == bsa_pkg::REG_OBJECT_SIZE) object_size <= cfg_data[11:0];
      else base_page <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.derive_start) begin
      db <= 7'd1; dphase <= 1'b0; dcnt <= '0;
    end else if (ctl.derive_step) begin
      if (!dphase) begin
        if (dpass || db == 7'(MAX_BITMAP_BYTES)) begin
          bm_bytes <= db;
          dphase <= 1'b1;
          drem <= '0;
          dnum <= 12'(AVAIL) - 12'(db);
          dcnt <= '0;
          dq <= '0;
        end else db <= db + 7'd1;
      end else if (dcnt != 4'd12) begin
        // restoring division, one quotient bit a step
        if (dtrial >= size_r) begin
          drem <= 12'(dtrial - size_r);
          dq <= {dq[10:0], 1'b1};
        end else begin
          drem <= dtrial[11:0];
          dq <= {dq[10:0], 1'b0};
        end
        dnum <= {dnum[10:0], 1'b0};
        dcnt <= dcnt + 4'd1;
      end
    end
  end
  assign sts.derive_done = dphase && (dcnt == 4'd12) && !init_clr;

  always_ff @(posedge clk) begin
    if (ctl.derive_step && sts.derive_done)
      per_slab <= (dq > 12'd512) ? 10'd512 : dq[9:0];
    else if (rst) per_slab <= 10'd63;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= '0; open_cnt <= OW'(1);
      result_valid <= 1'b0;
    end else begin
      result_valid <= ctl.emit;
      if (ctl.set_full) full[aslab] <= 1'b1;
      if (ctl.open_page) open_cnt <= open_cnt + OW'(1);
      if (ctl.free_commit) full[fslab] <= 1'b0;
    end
  end

  // clear pass: the first slab after reset, each new page when opened
  always_ff @(posedge clk) begin
    if (rst) begin
      init_clr <= 1'b1;
      clr_addr <= '0;
      clr_cnt <= '0;
    end else if (ctl.open_page) begin
      clr_addr <= {SW'(open_cnt), 3'd0};
      clr_cnt <= '0;
    end else if (ctl.clear_word || init_clr) begin
      clr_addr <= clr_addr + AW'(1);
      clr_cnt <= clr_cnt + 3'd1;
      if (clr_cnt == 3'd7) init_clr <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch_in) latched_addr <= free_address;
    if (ctl.pick) begin
      aslab <= SW'(open_cnt - OW'(1));
      for (int i = MAX_SLABS - 1; i >= 0; i--)
        if (i < int'(open_cnt) && !full[i]) aslab <= SW'(i);
      aword <= '0;
    end else if (ctl.scan_word && !has_free) aword <= aword + 3'd1;
    if (ctl.div_start) begin
      fslab <= SW'(rel); fnum <= off - first; frem <= '0; fcnt <= '0; fq <= '0;
    end else if (ctl.div_step && fcnt != 4'd12) begin
      if (ftrial >= size_r) begin
        frem <= 12'(ftrial - size_r);
        fq <= {fq[10:0], 1'b1};
      end else begin
        frem <= ftrial[11:0];
        fq <= {fq[10:0], 1'b0};
      end
      fnum <= {fnum[10:0], 1'b0};
      fcnt <= fcnt + 4'd1;
    end
  end

  // bitmap memory
  always_ff @(posedge clk) begin
    if (ctl.clear_word || init_clr) mem[clr_addr] <= '0;
    else if (ctl.scan_word && has_free) mem[addr] <= rdw | (64'd1 << fbit);
    else if (ctl.free_commit) mem[addr] <= rdw & ~(64'd1 << fq[5:0]);
    if (ctl.rd_word || ctl.rd_free) rdw <= mem[addr];
  end

  assign sts.word_has_free = has_free;
  assign sts.word_last = (aword == 3'd7);
  assign sts.slabs_all_open = (open_cnt >= OW'(MAX_SLABS));
  assign sts.clear_done = (clr_cnt == 3'd7);
  assign sts.free_bad = (rel >= 36'(open_cnt)) || (off < first);
  assign sts.div_done = (fcnt == 4'd12);
  assign sts.div_bad = (fq >= 12'(per_slab));
  assign sts.slot_set = rdw[fq[5:0]];

  always_ff @(posedge clk) if (ctl.latch_in) cmd_l <= cmd;

  logic [47:0] page_addr;
  assign page_addr = {36'(base_page + 36'(aslab)), 12'd0};
  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      status <= ctl.res_status;
      if (ctl.res_status == bsa_pkg::ST_OK && cmd_l == bsa_pkg::CMD_ALLOC)
        object_address <= page_addr + 48'(first) + 48'(mulp);
      else object_address <= '0;
    end
  end
endmodule

// File: rtl/core/bitmap_slab_allocator.sv
// Top level of the bitmap slab allocator: controller plus datapath.
// Depends on bsa_pkg, bsa_ctrl, bsa_datapath.
//
// channel  | signals                          | handshake
// config   | cfg_we, cfg_index, cfg_data      | write when cfg_we high
// command  | cmd, free_address                | start && !busy
// result   | object_address, status           | one-cycle result_valid strobe
//
// An allocate runs a pick step, a read and a scan step per bitmap word (up to
// 8 per slab) and a final state that strobes the result; each full slab that
// opens a page adds an open step and an 8-word clear. A free runs a check, a
// 12-step divider, a bitmap read and a test, and ends after the check when
// page or offset is rejected. After reset and each object_size write taken
// while idle, derivation runs with busy high; after reset the first slab's 8
// bitmap words are cleared in parallel. The receiver cannot stall results.
`timescale 1ns / 1ps
module bitmap_slab_allocator #(
  parameter int MAX_SLABS = 8,
  parameter int HEADER_BYTES = 64,
  parameter int MAX_BITMAP_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [35:0] cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic [47:0] free_address,
  output logic        result_valid,
  output logic [47:0] object_address,
  output logic [1:0]  status
);
  bsa_pkg::ctl_t ctl;
  bsa_pkg::sts_t sts;

  bsa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd),
    .cfg_size_we(cfg_we && cfg_index == bsa_pkg::REG_OBJECT_SIZE),
    .sts(sts), .busy(busy), .ctl(ctl)
  );

  bsa_datapath #(
    .MAX_SLABS(MAX_SLABS), .HEADER_BYTES(HEADER_BYTES),
    .MAX_BITMAP_BYTES(MAX_BITMAP_BYTES)
  ) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd), .free_address(free_address), .ctl(ctl), .sts(sts),
    .result_valid(result_valid), .object_address(object_address), .status(status)
  );
endmodule

// File: sim/bitmap_slab_allocator_tb.sv
// Self-checking testbench for bitmap_slab_allocator: directed and random
// allocate/free beats checked against an in-bench allocator model.
// Depends on bsa_pkg and the bitmap_slab_allocator RTL.
`timescale 1ns / 1ps
module bitmap_slab_allocator_tb;
  localparam int NSLABS = 8;
  localparam int HDR = 64;
  localparam int AVAIL = 4096 - HDR;
  localparam int IDLE_LIMIT = 4000;
  localparam logic [63:0] PMASK = 64'hF_FFFF_FFFF;

  typedef enum logic [1:0] {K_ALLOC, K_LIVE, K_DEAD, K_RAW} kind_t;
  typedef struct {
    kind_t       kind;
    logic [47:0] addr;
  } beat_t;
  typedef struct {
    logic [47:0] addr;
    logic [1:0]  st;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = bsa_pkg::REG_OBJECT_SIZE;
  logic [35:0] cfg_data = '0;
  logic        start = 1'b0;
  logic        cmd = bsa_pkg::CMD_ALLOC;
  logic [47:0] free_address = '0;
  logic        busy, result_valid;
  logic [47:0] object_address;
  logic [1:0]  status;

  bitmap_slab_allocator dut (.*);

  // allocator model state
  logic [63:0] slot_map [NSLABS*8];
  logic [NSLABS-1:0] full_marks;
  int          open_cnt, bmp_bytes, per_slab, osize;
  logic [63:0] base_page;

  beat_t       pending_beats[$];
  outcome_t    expected_q[$];
  logic [47:0] live_objs[$];
  logic [47:0] freed_objs[$];
  int          gap, idle_cnt, errors, n_alloc, n_free;
  int          st_seen [4];
  bit          quiet;

  initial forever #5 clk = ~clk;

  function automatic int rsize();
    int s;
    s = (osize + 7) & ~7;
    return s == 0 ? 8 : s;
  endfunction

  function automatic logic [47:0] slot_addr(int s, int i);
    logic [63:0] p;
    p = (base_page + s) & PMASK;
    return 48'((p << 12) + HDR + bmp_bytes + 64'(rsize()) * i);
  endfunction

  task automatic rederive();
    int b, n;
    bmp_bytes = 64;
    for (b = 1; b <= 64; b++) begin
      if ((AVAIL - b) / (b * 8) <= rsize()) begin
        bmp_bytes = b;
        break;
      end
    end
    n = (AVAIL - bmp_bytes) / rsize();
    per_slab = n > 512 ? 512 : n;
  endtask

  // rebuild the list of freeable objects after the layout moves
  task automatic rebuild_live();
    live_objs.delete();
    freed_objs.delete();
    for (int s = 0; s < open_cnt; s++)
      for (int i = 0; i < per_slab; i++)
        if (slot_map[s*8 + ((i >> 6) & 7)][i & 63]) live_objs.push_back(slot_addr(s, i));
  endtask

  task automatic take_object(output logic [1:0] st, output logic [47:0] a);
    int s;
    a = '0;
    forever begin
      s = open_cnt - 1;
      for (int i = 0; i < open_cnt; i++)
        if (!full_marks[i]) begin
          s = i;
          break;
        end
      for (int i = 0; i < per_slab; i++) begin
        if (!slot_map[s*8 + ((i >> 6) & 7)][i & 63]) begin
          slot_map[s*8 + ((i >> 6) & 7)][i & 63] = 1'b1;
          a = slot_addr(s, i);
          st = bsa_pkg::ST_OK;
          return;
        end
      end
      full_marks[s] = 1'b1;
      if (open_cnt >= NSLABS) begin
        st = bsa_pkg::ST_NOSLAB;
        return;
      end
      for (int w = 0; w < 8; w++) slot_map[open_cnt*8 + w] = '0;
      open_cnt++;
    end
  endtask

  task automatic return_object(input logic [47:0] a, output logic [1:0] st);
    logic [63:0] rel;
    int off, first, s, idx;
    logic [47:0] canon;
    rel = ((64'(a) >> 12) - base_page) & PMASK;
    off = int'(a[11:0]);
    first = HDR + bmp_bytes;
    if (rel >= open_cnt || off < first) begin
      st = bsa_pkg::ST_BADADDR;
      return;
    end
    s = int'(rel);
    idx = (off - first) / rsize();
    if (idx >= per_slab) st = bsa_pkg::ST_BADADDR;
    else if (!slot_map[s*8 + ((idx >> 6) & 7)][idx & 63]) st = bsa_pkg::ST_DOUBLE;
    else begin
      slot_map[s*8 + ((idx >> 6) & 7)][idx & 63] = 1'b0;
      full_marks[s] = 1'b0;
      canon = slot_addr(s, idx);
      foreach (live_objs[k])
        if (live_objs[k] == canon) begin
          live_objs.delete(k);
          break;
        end
      freed_objs.push_back(canon);
      st = bsa_pkg::ST_OK;
    end
  endtask

  task automatic predict_beat(input logic c, input logic [47:0] a);
    outcome_t e;
    if (c == bsa_pkg::CMD_ALLOC) begin
      take_object(e.st, e.addr);
      if (e.st == bsa_pkg::ST_OK) live_objs.push_back(e.addr);
      n_alloc++;
    end else begin
      e.addr = '0;
      return_object(a, e.st);
      n_free++;
    end
    st_seen[e.st]++;
    expected_q.push_back(e);
  endtask

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // driver: present queued beats, resolving free targets at launch time
  always @(posedge clk) begin : driver
    logic nxt;
    beat_t b;
    logic [47:0] a;
    if (rst) begin
      start <= 1'b0;
      gap = 0;
    end else begin
      nxt = start;
      if (start && !busy) begin
        predict_beat(cmd, free_address);
        nxt = 1'b0;
        if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 11);
      end
      if (!nxt) begin
        if (gap > 0) gap--;
        else if (pending_beats.size() > 0) begin
          b = pending_beats.pop_front();
          a = b.addr;
          if (b.kind == K_LIVE && live_objs.size() > 0)
            a = live_objs[$urandom_range(0, live_objs.size() - 1)]
                + (b.addr[0] ? 48'($urandom_range(0, rsize() - 1)) : 48'd0);
          else if (b.kind == K_DEAD && freed_objs.size() > 0)
            a = freed_objs[$urandom_range(0, freed_objs.size() - 1)];
          else if (b.kind == K_LIVE || b.kind == K_DEAD)
            a = slot_addr($urandom_range(0, NSLABS - 1), $urandom_range(0, 8));
          cmd <= (b.kind == K_ALLOC) ? bsa_pkg::CMD_ALLOC : bsa_pkg::CMD_FREE;
          free_address <= a;
          nxt = 1'b1;
        end
      end
      start <= nxt;
    end
  end

  // monitor: results arrive as one-cycle strobes
  always @(posedge clk) begin : monitor
    outcome_t e;
    if (!rst && result_valid) begin
      if (expected_q.size() == 0)
        flag_error($sformatf("unexpected result addr=%h status=%0d", object_address, status));
      else begin
        e = expected_q.pop_front();
        if (object_address !== e.addr || status !== e.st)
          flag_error($sformatf("mismatch: exp addr=%h status=%0d, got addr=%h status=%0d",
                               e.addr, e.st, object_address, status));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (start && !busy) || result_valid) idle_cnt <= 0;
    else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt == IDLE_LIMIT) begin
        $display("bitmap_slab_allocator_tb: done, errors");
        $finish;
      end
    end
  end

  task automatic push(kind_t k, logic [47:0] a);
    beat_t b;
    b.kind = k;
    b.addr = a;
    pending_beats.push_back(b);
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_beats.size() > 0 || start || expected_q.size() > 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [35:0] val);
    drain();
    while (busy) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == bsa_pkg::REG_OBJECT_SIZE) begin
      osize = int'(val[11:0]);
      rederive();
    end else base_page = 64'(val);
    rebuild_live();
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  task automatic random_beats(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 55) push(K_ALLOC, 48'({$urandom, $urandom}));
      else if (r < 80) push(K_LIVE, 48'($urandom_range(0, 2) == 0));
      else if (r < 88) push(K_DEAD, '0);
      else if (r < 94)
        push(K_RAW, 48'((((base_page + $urandom_range(0, NSLABS)) & PMASK) << 12)
                        + $urandom_range(0, 4095)));
      else push(K_RAW, 48'({$urandom, $urandom}));
    end
  endtask

  initial begin : stimulus
    logic [47:0] a0;
    foreach (slot_map[i]) slot_map[i] = '0;
    full_marks = '0;
    open_cnt = 1;
    osize = 64;
    base_page = '0;
    rederive();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // one object per page, region wrapping past the top page number
    write_reg(bsa_pkg::REG_OBJECT_SIZE, 36'd2048);
    write_reg(bsa_pkg::REG_BASE_PAGE, 36'hF_FFFF_FFFF);
    repeat (9) push(K_ALLOC, '0);
    a0 = slot_addr(0, 0);
    push(K_RAW, a0);
    push(K_RAW, a0);
    push(K_RAW, a0 - 48'd10);
    push(K_RAW, slot_addr(0, 1));
    push(K_RAW, a0 - 48'd4096);
    push(K_RAW, 48'hFFFF_FFFF_FFFF);
    push(K_LIVE, 48'd1);
    push(K_ALLOC, '0);
    push(K_ALLOC, '0);
    push(K_ALLOC, '0);
    write_reg(bsa_pkg::REG_OBJECT_SIZE, 36'd4095);
    push(K_ALLOC, '0);
    push(K_RAW, slot_addr(1, 0));
    write_reg(bsa_pkg::REG_OBJECT_SIZE, 36'd0);
    push(K_ALLOC, '0);
    push(K_ALLOC, '0);
    push(K_LIVE, 48'd0);
    push(K_DEAD, '0);

    write_reg(bsa_pkg::REG_OBJECT_SIZE, 36'd8);
    write_reg(bsa_pkg::REG_BASE_PAGE, 36'({$urandom, $urandom}));
    random_beats(100);
    write_reg(bsa_pkg::REG_OBJECT_SIZE, 36'd2048);
    write_reg(bsa_pkg::REG_BASE_PAGE, 36'd0);
    random_beats(100);
    write_reg(bsa_pkg::REG_OBJECT_SIZE, 36'($urandom_range(0, 4095)));
    write_reg(bsa_pkg::REG_BASE_PAGE, 36'({$urandom, $urandom}));
    random_beats(100);
    write_reg(bsa_pkg::REG_OBJECT_SIZE, 36'd4095);
    random_beats(60);
    write_reg(bsa_pkg::REG_OBJECT_SIZE, 36'd256);
    write_reg(bsa_pkg::REG_BASE_PAGE, 36'h8_0000_0000);
    random_beats(120);
    write_reg(bsa_pkg::REG_OBJECT_SIZE, 36'd24);
    write_reg(bsa_pkg::REG_BASE_PAGE, 36'hF_FFFF_FFFE);
    random_beats(100);
    write_reg(bsa_pkg::REG_OBJECT_SIZE, 36'($urandom_range(1, 600)));
    random_beats(60);
    write_reg(bsa_pkg::REG_OBJECT_SIZE, 36'd64);
    write_reg(bsa_pkg::REG_BASE_PAGE, 36'($urandom));
    quiet = 1'b1;
    random_beats(60);
    drain();
    repeat (100) @(posedge clk);

    if (expected_q.size() > 0) flag_error("results still outstanding at end of run");
    $display("covered %0d allocates and %0d frees across several size and base settings",
             n_alloc, n_free);
    $display("status mix: ok=%0d no-slab=%0d double=%0d bad-addr=%0d, mismatches=%0d",
             st_seen[0], st_seen[1], st_seen[2], st_seen[3], errors);
    if (errors == 0) $display("bitmap_slab_allocator_tb: done, clean");
    else $display("bitmap_slab_allocator_tb: done, errors");
    $finish;
  end
endmodule

// File: files.f
rtl/core/bsa_pkg.sv
rtl/core/bsa_ctrl.sv
rtl/core/bsa_datapath.sv
rtl/core/bitmap_slab_allocator.sv
sim/bitmap_slab_allocator_tb.sv
